// ===== sv/kfsi_pkg.sv =====
package kfsi_pkg;

    // input action codes
    typedef enum logic [1:0] {
        ACT_LOAD_ANGLE = 2'd0,
        ACT_LOAD_DUR   = 2'd1,
        ACT_COMPUTE    = 2'd2,
        ACT_NONE       = 2'd3
    } action_t;

    // register indexes
    localparam logic [0:0] REG_FRAME_COUNT = 1'b0;
    localparam logic [0:0] REG_CYCLE_MS    = 1'b1;

    localparam int NUM_OUT     = 10;
    localparam int ANGLE_W     = 8;
    localparam int DUR_W       = 16;
    localparam int TIME_W      = 32;
    localparam int CYCLE_W     = 20;
    localparam int FCOUNT_W    = 5;
    localparam int OUT_W       = 16;
    // 256*(a*(d-o)+b*o) < 2^8 * 2^8 * 2^16 * 2
    localparam int NUM_W       = 33;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MOD,
        ST_WALK_RD,
        ST_WALK,
        ST_DUR_RD,
        ST_DUR,
        ST_ANG_RD_A,
        ST_ANG_RD_B,
        ST_ANG_WAIT,
        ST_DIV,
        ST_STORE,
        ST_OUT
    } state_t;

endpackage

// ===== sv/kfsi_ram.sv =====
module kfsi_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // one write port, registered read
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== sv/keyframe_servo_interpolator.sv =====
// Channel | Dir | Handshake              | Payload
// s_axis  | in  | s_axis_tvalid/tready   | tdata: action, frame, joint, angle_deg,
//         |     |                        |        duration_ms, time_ms
// m_axis  | out | m_axis_tvalid/tready   | tdata: angle_j0 .. angle_j9
// apb     | in  | psel/penable/pready    | frame_count @0x0, cycle_ms @0x4
//
// A compute request reduces the time modulo cycle_ms (one bit a cycle), walks
// the frames and then divides bit-serially for each joint.
// Reset clears control and sets frame_count to 1 and cycle_ms to 2000;
// the tables are undefined until loaded.
// One request at a time: s_axis_tready is low while a compute is under way or a
// result waits in the output register.
module keyframe_servo_interpolator
    import kfsi_pkg::*;
#(
    parameter int MAX_FRAMES = 16,
    parameter int JOINTS     = 10
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // action[1:0], frame[5:2], joint[9:6], angle_deg[17:10],
    // duration_ms[33:18], time_ms[65:34], zeros[71:66]
    input  logic [71:0]  s_axis_tdata,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // angle_j0[15:0], angle_j1[31:16] ... angle_j9[159:144]
    output logic [159:0] m_axis_tdata,
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [2:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready
);

    localparam int FI_W   = $clog2(MAX_FRAMES);
    localparam int ADEPTH = MAX_FRAMES * JOINTS;
    localparam int AA_W   = $clog2(ADEPTH);
    localparam int JI_W   = (JOINTS > 1) ? $clog2(JOINTS) : 1;
    localparam int FN_W   = $clog2(MAX_FRAMES + 1);

    // input fields
    logic [1:0]        in_action;
    logic [3:0]        in_frame;
    logic [3:0]        in_joint;
    logic [7:0]        in_angle;
    logic [15:0]       in_dur;
    logic [31:0]       in_time;
    assign in_action = s_axis_tdata[1:0];
    assign in_frame  = s_axis_tdata[5:2];
    assign in_joint  = s_axis_tdata[9:6];
    assign in_angle  = s_axis_tdata[17:10];
    assign in_dur    = s_axis_tdata[33:18];
    assign in_time   = s_axis_tdata[65:34];

    // configuration registers
    logic [FCOUNT_W-1:0] frame_count_reg;
    logic [CYCLE_W-1:0]  cycle_ms_reg;
    logic                cfg_wr;
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_count_reg <= FCOUNT_W'(1);
            cycle_ms_reg    <= CYCLE_W'(2000);
        end
        else if (cfg_wr)
        begin
            if (paddr[2] == REG_FRAME_COUNT)
                frame_count_reg <= pwdata[FCOUNT_W-1:0];
            else
                cycle_ms_reg <= pwdata[CYCLE_W-1:0];
        end
    end

    always_comb
    begin
        if (paddr[2] == REG_FRAME_COUNT)
            prdata = {{(32-FCOUNT_W){1'b0}}, frame_count_reg};
        else
            prdata = {{(32-CYCLE_W){1'b0}}, cycle_ms_reg};
    end

    // state
    state_t              state_reg, state_next;
    logic [TIME_W-1:0]   rem_reg, rem_next;       // modulo remainder / phase
    logic [TIME_W-1:0]   tq_reg, tq_next;         // dividend shift register
    logic [5:0]          cnt_reg, cnt_next;
    logic [FI_W-1:0]     fi_reg, fi_next;
    logic [FN_W-1:0]     n_reg, n_next;
    logic [DUR_W-1:0]    d_reg, d_next;
    logic [JI_W-1:0]     j_reg, j_next;
    logic [ANGLE_W-1:0]  a_reg, a_next;
    logic [NUM_W-1:0]    num_reg, num_next;
    logic [NUM_W-1:0]    quo_reg, quo_next;
    logic [DUR_W:0]      drem_reg, drem_next;
    logic [OUT_W-1:0]    res_reg [NUM_OUT];
    logic                res_we;
    logic                out_valid_reg, out_valid_next;

    // memories
    logic                dur_we;
    logic [FI_W-1:0]     dur_waddr, dur_raddr;
    logic [DUR_W-1:0]    dur_rdata;
    logic                ang_we;
    logic [AA_W-1:0]     ang_waddr, ang_raddr;
    logic [ANGLE_W-1:0]  ang_rdata;

    kfsi_ram #(.WIDTH(DUR_W), .DEPTH(MAX_FRAMES)) u_dur_ram (
        .clk   (clk),
        .we    (dur_we),
        .waddr (dur_waddr),
        .wdata (in_dur),
        .raddr (dur_raddr),
        .rdata (dur_rdata)
    );

    kfsi_ram #(.WIDTH(ANGLE_W), .DEPTH(ADEPTH)) u_ang_ram (
        .clk   (clk),
        .we    (ang_we),
        .waddr (ang_waddr),
        .wdata (in_angle),
        .raddr (ang_raddr),
        .rdata (ang_rdata)
    );

    logic accept;
    assign s_axis_tready = (state_reg == ST_IDLE) && !out_valid_reg;
    assign accept        = s_axis_tvalid && s_axis_tready;

    // load writes
    assign dur_we    = accept && (in_action == ACT_LOAD_DUR) && (32'(in_frame) < MAX_FRAMES);
    assign dur_waddr = FI_W'(in_frame);
    assign ang_we    = accept && (in_action == ACT_LOAD_ANGLE)
                       && (32'(in_frame) < MAX_FRAMES) && (32'(in_joint) < JOINTS);
    assign ang_waddr = AA_W'(32'(in_frame) * JOINTS + 32'(in_joint));

    // helpers
    logic [FI_W-1:0]  nxt_fi;
    logic [TIME_W:0]  mod_trial;
    logic [DUR_W+1:0] div_trial;
    logic [TIME_W:0]  rem_shift;
    logic [DUR_W+1:0] drem_shift;
    assign nxt_fi     = (32'(fi_reg) + 1 == 32'(n_reg)) ? '0 : FI_W'(32'(fi_reg) + 1);
    assign rem_shift  = {rem_reg, tq_reg[TIME_W-1]};
    assign mod_trial  = rem_shift - {{(TIME_W+1-CYCLE_W){1'b0}}, cycle_ms_reg};
    assign drem_shift = {drem_reg, num_reg[NUM_W-1]};
    assign div_trial  = drem_shift - {2'b00, d_reg};

    always_comb
    begin
        state_next     = state_reg;
        rem_next       = rem_reg;
        tq_next        = tq_reg;
        cnt_next       = cnt_reg;
        fi_next        = fi_reg;
        n_next         = n_reg;
        d_next         = d_reg;
        j_next         = j_reg;
        a_next         = a_reg;
        num_next       = num_reg;
        quo_next       = quo_reg;
        drem_next      = drem_reg;
        out_valid_next = out_valid_reg;
        res_we         = 1'b0;
        dur_raddr      = fi_reg;
        ang_raddr      = AA_W'(32'(fi_reg) * JOINTS + 32'(j_reg));

        if (out_valid_reg && m_axis_tready)
            out_valid_next = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (accept && in_action == ACT_COMPUTE)
                begin
                    tq_next  = in_time;
                    rem_next = '0;
                    cnt_next = '0;
                    fi_next  = '0;
                    j_next   = '0;
                    if (frame_count_reg == '0)
                        n_next = FN_W'(1);
                    else if (32'(frame_count_reg) > MAX_FRAMES)
                        n_next = FN_W'(MAX_FRAMES);
                    else
                        n_next = FN_W'(frame_count_reg);
                    state_next = ST_MOD;
                end
            end
            // restoring remainder, one dividend bit a cycle
            ST_MOD:
            begin
                if (cycle_ms_reg == '0)
                begin
                    rem_next   = '0;
                    state_next = ST_WALK_RD;
                end
                else
                begin
                    if (!mod_trial[TIME_W])
                        rem_next = mod_trial[TIME_W-1:0];
                    else
                        rem_next = rem_shift[TIME_W-1:0];
                    tq_next  = {tq_reg[TIME_W-2:0], 1'b0};
                    cnt_next = cnt_reg + 6'd1;
                    if (cnt_reg == 6'(TIME_W - 1))
                        state_next = ST_WALK_RD;
                end
            end
            ST_WALK_RD:
            begin
                if (32'(fi_reg) + 1 < 32'(n_reg))
                    state_next = ST_WALK;
                else
                    state_next = ST_DUR_RD;
            end
            ST_WALK:
            begin
                if (rem_reg < TIME_W'(dur_rdata))
                    state_next = ST_DUR_RD;
                else
                begin
                    rem_next   = rem_reg - TIME_W'(dur_rdata);
                    fi_next    = FI_W'(32'(fi_reg) + 1);
                    state_next = ST_WALK_RD;
                end
            end
            ST_DUR_RD:
            begin
                state_next = ST_DUR;
            end
            ST_DUR:
            begin
                d_next = dur_rdata;
                if (rem_reg > TIME_W'(dur_rdata))
                    rem_next = TIME_W'(dur_rdata);
                state_next = ST_ANG_RD_A;
            end
            ST_ANG_RD_A:
            begin
                state_next = ST_ANG_RD_B;
            end
            ST_ANG_RD_B:
            begin
                a_next     = ang_rdata;
                ang_raddr  = AA_W'(32'(nxt_fi) * JOINTS + 32'(j_reg));
                state_next = ST_ANG_WAIT;
            end
            // form the numerator, then divide bit-serially by d (a zero d takes the next angle)
            ST_ANG_WAIT:
            begin
                num_next = NUM_W'({(32'(a_reg) * (32'(d_reg) - rem_reg[31:0])
                                    + 32'(ang_rdata) * rem_reg[31:0]), 8'd0});
                quo_next  = '0;
                drem_next = '0;
                cnt_next  = '0;
                if (d_reg == '0)
                begin
                    quo_next   = NUM_W'({ang_rdata, 8'd0});
                    state_next = ST_STORE;
                end
                else
                    state_next = ST_DIV;
            end
            ST_DIV:
            begin
                if (!div_trial[DUR_W+1])
                begin
                    drem_next = div_trial[DUR_W:0];
                    quo_next  = {quo_reg[NUM_W-2:0], 1'b1};
                end
                else
                begin
                    drem_next = drem_shift[DUR_W:0];
                    quo_next  = {quo_reg[NUM_W-2:0], 1'b0};
                end
                num_next = {num_reg[NUM_W-2:0], 1'b0};
                cnt_next = cnt_reg + 6'd1;
                if (cnt_reg == 6'(NUM_W - 1))
                    state_next = ST_STORE;
            end
            ST_STORE:
            begin
                res_we = 1'b1;
                if (32'(j_reg) + 1 == JOINTS)
                    state_next = ST_OUT;
                else
                begin
                    j_next     = JI_W'(32'(j_reg) + 1);
                    state_next = ST_ANG_RD_A;
                end
            end
            ST_OUT:
            begin
                out_valid_next = 1'b1;
                state_next     = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg  <= rem_next;
        tq_reg   <= tq_next;
        cnt_reg  <= cnt_next;
        fi_reg   <= fi_next;
        n_reg    <= n_next;
        d_reg    <= d_next;
        j_reg    <= j_next;
        a_reg    <= a_next;
        num_reg  <= num_next;
        quo_reg  <= quo_next;
        drem_reg <= drem_next;
    end

    // result lanes; lanes past JOINTS stay zero
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < NUM_OUT; k++)
                res_reg[k] <= '0;
        end
        else if (res_we)
        begin
            for (int k = 0; k < NUM_OUT; k++)
                if (k < JOINTS && 32'(j_reg) == k)
                    res_reg[k] <= quo_reg[OUT_W-1:0];
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    always_comb
    begin
        for (int k = 0; k < NUM_OUT; k++)
            m_axis_tdata[k*OUT_W +: OUT_W] = res_reg[k];
    end

endmodule

// ===== sv/kfsi_checker.sv =====
module kfsi_checker
    import kfsi_pkg::*;
(
    input logic         clk,
    input logic         rst_n,
    input logic         s_axis_tvalid,
    input logic         s_axis_tready,
    input logic [71:0]  s_axis_tdata,
    input logic         m_axis_tvalid,
    input logic         m_axis_tready,
    input logic [159:0] m_axis_tdata
);

    // a waiting result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result dropped or changed while stalled");

    // no new request while a result waits
    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> !s_axis_tready)
        else $error("input ready while result pending");

    // a compute request occupies the block
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready && s_axis_tdata[1:0] == ACT_COMPUTE |=> !s_axis_tready)
        else $error("ready right after compute request");

    // a load never produces a result next cycle
    a_load_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready
        && (s_axis_tdata[1:0] == ACT_LOAD_ANGLE || s_axis_tdata[1:0] == ACT_LOAD_DUR)
        |=> !m_axis_tvalid)
        else $error("result after load request");

endmodule

bind keyframe_servo_interpolator kfsi_checker u_kfsi_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

// ===== tb/tb_keyframe_servo_interpolator.sv =====
`timescale 1ns / 1ps

module tb_keyframe_servo_interpolator;
    import kfsi_pkg::*;

    localparam int FRAMES     = 16;
    localparam int JNT        = 10;
    localparam int IDLE_LIMIT = 20000;
    localparam int SETTLE     = 600;

    typedef struct packed {
        logic [31:0] time_ms;
        logic [15:0] duration_ms;
        logic [7:0]  angle_deg;
        logic [3:0]  joint;
        logic [3:0]  frame;
        action_t     action;
    } gait_req_t;

    // Gait predictor: mirrors the keyframe tables and registers, queues poses
    class gait_scoreboard;
        logic [7:0]    angle_mem [FRAMES*JNT];
        logic [15:0]   dur_mem [FRAMES];
        logic [4:0]    frame_count;
        logic [19:0]   cycle_len;
        logic [159:0]  pose_q[$];
        int            errors;

        function new();
            frame_count = 5'd1;
            cycle_len   = 20'd2000;
            errors      = 0;
        endfunction

        function void write_reg(logic [0:0] idx, logic [31:0] val);
            if (idx == REG_FRAME_COUNT)
                frame_count = val[4:0];
            else
                cycle_len = val[19:0];
        endfunction

        function logic [159:0] pose_at(logic [31:0] t);
            int unsigned        n, i, nxt;
            longint unsigned    ph, d, a, b, v;
            logic [159:0]       pose;
            n = frame_count;
            if (n == 0) n = 1;
            if (n > FRAMES) n = FRAMES;
            ph = (cycle_len == 0) ? 0 : (t % cycle_len);
            for (i = 0; i + 1 < n; i++) begin
                if (ph < dur_mem[i]) break;
                ph -= dur_mem[i];
            end
            nxt = (i + 1 == n) ? 0 : i + 1;
            d = dur_mem[i];
            // offset past the last frame holds at the next keyframe
            if (ph > d) ph = d;
            pose = '0;
            for (int j = 0; j < JNT; j++) begin
                a = angle_mem[i*JNT + j];
                b = angle_mem[nxt*JNT + j];
                v = (d == 0) ? b * 256 : (256 * (a * (d - ph) + b * ph)) / d;
                pose[16*j +: 16] = v[15:0];
            end
            return pose;
        endfunction

        function void note_request(gait_req_t r);
            case (r.action)
                ACT_LOAD_ANGLE: if (r.joint < JNT) angle_mem[r.frame*JNT + r.joint] = r.angle_deg;
                ACT_LOAD_DUR:   dur_mem[r.frame] = r.duration_ms;
                ACT_COMPUTE:    pose_q.push_back(pose_at(r.time_ms));
                default: ;
            endcase
        endfunction

        function void check_pose(logic [159:0] got);
            logic [159:0] exp_pose;
            if (pose_q.size() == 0) begin
                $display("%0t: unexpected pose %h", $time, got);
                errors++;
                return;
            end
            exp_pose = pose_q.pop_front();
            for (int j = 0; j < JNT; j++)
                if (got[16*j +: 16] !== exp_pose[16*j +: 16]) begin
                    $display("%0t: angle_j%0d expected %0d actual %0d", $time, j,
                             exp_pose[16*j +: 16], got[16*j +: 16]);
                    errors++;
                end
        endfunction
    endclass

    logic         clk;
    logic         rst_n;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    logic [71:0]  s_axis_tdata;
    logic         m_axis_tvalid;
    logic         m_axis_tready;
    logic [159:0] m_axis_tdata;
    logic         psel;
    logic         penable;
    logic         pwrite;
    logic [2:0]   paddr;
    logic [31:0]  pwdata;
    logic [31:0]  prdata;
    logic         pready;

    gait_scoreboard sb = new();
    int  idle_cycles;
    int  burst_left;
    int  stall_mode;

    keyframe_servo_interpolator DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // receiver stall pattern, changes character at random
    always @(posedge clk)
    begin
        if ($urandom_range(0, 255) == 0)
            stall_mode <= $urandom_range(0, 2);
        case (stall_mode)
            0:       m_axis_tready <= 1'b1;
            1:       m_axis_tready <= ($urandom_range(0, 1) == 1);
            default: m_axis_tready <= ($urandom_range(0, 7) == 0);
        endcase
    end

    // result check and idle watchdog
    always @(posedge clk)
    begin
        if (m_axis_tvalid && m_axis_tready)
            sb.check_pose(m_axis_tdata);
        if ((m_axis_tvalid && m_axis_tready) || (s_axis_tvalid && s_axis_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    task automatic send_request(gait_req_t r);
        if (burst_left == 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge clk);
            burst_left = ($urandom_range(0, 3) == 0) ? 40 : $urandom_range(1, 8);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {6'b0, r};
        do @(posedge clk); while (!s_axis_tready);
        sb.note_request(r);
        burst_left--;
    endtask

    task automatic load_angle(int f, int j, int deg);
        gait_req_t r;
        r = '0;
        r.action = ACT_LOAD_ANGLE;
        r.frame = 4'(f); r.joint = 4'(j); r.angle_deg = 8'(deg);
        r.duration_ms = 16'($urandom); r.time_ms = $urandom;
        send_request(r);
    endtask

    task automatic load_dur(int f, int ms);
        gait_req_t r;
        r = '0;
        r.action = ACT_LOAD_DUR;
        r.frame = 4'(f); r.duration_ms = 16'(ms);
        r.joint = 4'($urandom); r.angle_deg = 8'($urandom); r.time_ms = $urandom;
        send_request(r);
    endtask

    task automatic compute(logic [31:0] t);
        gait_req_t r;
        r = '0;
        r.action = ACT_COMPUTE;
        r.time_ms = t;
        r.frame = 4'($urandom); r.joint = 4'($urandom); r.angle_deg = 8'($urandom);
        r.duration_ms = 16'($urandom);
        send_request(r);
    endtask

    // drain outstanding poses, let the block settle, then write a register
    task automatic apb_write(logic [0:0] idx, logic [31:0] val);
        s_axis_tvalid <= 1'b0;
        burst_left = 0;
        while (sb.pose_q.size() != 0) @(posedge clk);
        repeat (SETTLE) @(posedge clk);
        psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
        paddr <= {idx, 2'b00}; pwdata <= val;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        sb.write_reg(idx, val);
        psel <= 1'b0; penable <= 1'b0;
        @(posedge clk);
    endtask

    function automatic int dur_sum(int n);
        int s;
        s = 0;
        for (int f = 0; f < n; f++) s += sb.dur_mem[f];
        return s;
    endfunction

    function automatic logic [31:0] pick_time();
        int c;
        c = sb.cycle_len;
        if ($urandom_range(0, 4) == 0) return $urandom;
        return $urandom_range(0, 3 * c + 2);
    endfunction

    task automatic random_item();
        int k;
        k = $urandom_range(0, 99);
        if (k < 40)
            load_angle($urandom_range(0, 15), ($urandom_range(0, 19) == 0) ?
                       $urandom_range(10, 15) : $urandom_range(0, 9), $urandom_range(0, 180));
        else if (k < 55)
            case ($urandom_range(0, 9))
                0:       load_dur($urandom_range(0, 15), 0);
                1:       load_dur($urandom_range(0, 15), $urandom_range(1, 65535));
                default: load_dur($urandom_range(0, 15), $urandom_range(1, 400));
            endcase
        else if (k < 97)
            compute(pick_time());
        else
        begin
            gait_req_t r;
            r = 66'($urandom);
            r.action = ACT_NONE;
            r.time_ms = $urandom;
            send_request(r);
        end
    endtask

    initial
    begin
        int          fc, cl;
        gait_req_t   r;
        rst_n = 1'b0;
        s_axis_tvalid = 1'b0; s_axis_tdata = '0;
        m_axis_tready = 1'b0;
        psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
        idle_cycles = 0; burst_left = 0; stall_mode = 0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // fill every table entry before any compute reads one
        for (int f = 0; f < FRAMES; f++)
        begin
            load_dur(f, $urandom_range(1, 300));
            for (int j = 0; j < JNT; j++)
                load_angle(f, j, $urandom_range(0, 180));
        end

        // directed: reset config, extremes of angles and times
        load_angle(0, 0, 180); load_angle(1, 0, 0); load_angle(0, 9, 0);
        load_angle(1, 9, 180); load_angle(15, 15, 77);
        load_dur(0, 65535);
        compute(32'd0); compute(32'hFFFFFFFF); compute(32'd1999);
        apb_write(REG_FRAME_COUNT, 32'd2);
        compute(32'd1000); compute(32'd65534);
        // offset past the last frame saturates
        load_dur(0, 100); load_dur(1, 50);
        compute(32'd120); compute(32'd1500);
        // zero duration frame skipped, and reached as the last frame
        load_dur(0, 0);
        compute(32'd10); compute(32'd60);
        r = 66'($urandom); r.action = ACT_NONE; send_request(r);
        apb_write(REG_CYCLE_MS, 32'd0);
        compute(32'd12345);
        apb_write(REG_FRAME_COUNT, 32'd0);
        compute(32'd7);
        apb_write(REG_FRAME_COUNT, 32'd31);
        apb_write(REG_CYCLE_MS, 32'd1);
        compute(32'hFFFFFFFF);
        load_dur(15, 65535);
        apb_write(REG_CYCLE_MS, 32'hFFFFFFFF);
        compute(32'hFFFFFFFF); compute(32'd1048574);

        // random phases under changing settings
        for (int p = 0; p < 8; p++)
        begin
            case (p % 4)
                0: fc = $urandom_range(1, 16);
                1: fc = 16;
                2: fc = $urandom_range(17, 31);
                default: fc = $urandom_range(0, 2);
            endcase
            apb_write(REG_FRAME_COUNT, fc);
            case ($urandom_range(0, 5))
                0: cl = 0;
                1: cl = 1;
                2: cl = 1048575;
                3: cl = $urandom_range(1, 1048575);
                default: cl = dur_sum((fc == 0) ? 1 : (fc > 16 ? 16 : fc))
                              + $urandom_range(0, 40);
            endcase
            apb_write(REG_CYCLE_MS, cl);
            for (int k = 0; k < 88; k++)
                random_item();
        end

        s_axis_tvalid <= 1'b0;
        while (sb.pose_q.size() != 0) @(posedge clk);
        repeat (SETTLE) @(posedge clk);
        if (sb.errors == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
